FILE: design/qfr_pkg.sv
// Package for the quaternion frame rotation block.
// Holds the shared data types, word widths and fixed-point constants; depends on nothing.
package qfr_pkg;

  localparam int IN_W   = 16;
  localparam int PQ_W   = 32;           // quaternion part products
  localparam int ENT_W  = 34;           // matrix entries, units of 2^-28
  localparam int PROD_W = IN_W + ENT_W; // accel times entry
  localparam int SUM_W  = PROD_W + 2;   // three-term sum
  localparam int FRAC_BITS = 28;
  localparam int RND_W  = SUM_W - FRAC_BITS;

  typedef logic signed [IN_W-1:0]   s16_t;
  typedef logic signed [PQ_W-1:0]   pq_t;
  typedef logic signed [ENT_W-1:0]  ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  localparam ent_t ONE_FIX  = ent_t'(1) <<< FRAC_BITS;
  localparam sum_t HALF_FIX = sum_t'(1) <<< (FRAC_BITS - 1);
  localparam rnd_t SAT_MAX  = rnd_t'(32767);
  localparam rnd_t SAT_MIN  = -rnd_t'(32768);

  typedef struct packed {
    s16_t x;
    s16_t y;
    s16_t z;
  } vec_t;

  typedef struct packed {
    ent_t r00;
    ent_t r01;
    ent_t r02;
    ent_t r10;
    ent_t r11;
    ent_t r12;
    ent_t r20;
    ent_t r21;
    ent_t r22;
  } mat_t;

endpackage

FILE: design/qfr_matrix.sv
// Two pipeline stages that build the unnormalized rotation matrix of a quaternion.
// Stage one forms the part products, stage two the nine entries. Uses qfr_pkg.
module qfr_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qfr_pkg::s16_t  in_quat_w,
  input  qfr_pkg::s16_t  in_quat_x,
  input  qfr_pkg::s16_t  in_quat_y,
  input  qfr_pkg::s16_t  in_quat_z,
  input  qfr_pkg::vec_t  in_accel,
  output logic           out_valid,
  input  logic           out_ready,
  output qfr_pkg::mat_t  out_mat,
  output qfr_pkg::vec_t  out_accel
);
  import qfr_pkg::*;

  function automatic pq_t ext32(input s16_t v);
    return {{(PQ_W-IN_W){v[IN_W-1]}}, v};
  endfunction

  function automatic ent_t ext34(input pq_t v);
    return {{(ENT_W-PQ_W){v[PQ_W-1]}}, v};
  endfunction

  function automatic ent_t dbl(input ent_t v);
    return {v[ENT_W-2:0], 1'b0};
  endfunction

  logic va_r, vb_r;
  logic adv_a, adv_b;

  pq_t w32, x32, y32, z32;
  pq_t pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r, pwx_r, pwy_r, pwz_r;
  vec_t acc_a_r, acc_b_r;
  mat_t mat_nxt, mat_r;

  assign adv_b    = out_ready || !vb_r;
  assign adv_a    = adv_b || !va_r;
  assign in_ready = adv_a;

  assign w32 = ext32(in_quat_w);
  assign x32 = ext32(in_quat_x);
  assign y32 = ext32(in_quat_y);
  assign z32 = ext32(in_quat_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= in_valid;
      if (adv_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      pxx_r   <= x32 * x32;
      pyy_r   <= y32 * y32;
      pzz_r   <= z32 * z32;
      pxy_r   <= x32 * y32;
      pxz_r   <= x32 * z32;
      pyz_r   <= y32 * z32;
      pwx_r   <= w32 * x32;
      pwy_r   <= w32 * y32;
      pwz_r   <= w32 * z32;
      acc_a_r <= in_accel;
    end
  end

  always_comb begin
    mat_nxt.r00 = ONE_FIX - dbl(ext34(pyy_r) + ext34(pzz_r));
    mat_nxt.r01 = dbl(ext34(pxy_r) - ext34(pwz_r));
    mat_nxt.r02 = dbl(ext34(pxz_r) + ext34(pwy_r));
    mat_nxt.r10 = dbl(ext34(pxy_r) + ext34(pwz_r));
    mat_nxt.r11 = ONE_FIX - dbl(ext34(pxx_r) + ext34(pzz_r));
    mat_nxt.r12 = dbl(ext34(pyz_r) - ext34(pwx_r));
    mat_nxt.r20 = dbl(ext34(pxz_r) - ext34(pwy_r));
    mat_nxt.r21 = dbl(ext34(pyz_r) + ext34(pwx_r));
    mat_nxt.r22 = ONE_FIX - dbl(ext34(pxx_r) + ext34(pyy_r));
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      mat_r   <= mat_nxt;
      acc_b_r <= acc_a_r;
    end
  end

  assign out_valid = vb_r;
  assign out_mat   = mat_r;
  assign out_accel = acc_b_r;

  // diagonal entries never exceed one: squares only subtract
  a_diag_max: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (mat_r.r00 <= ONE_FIX && mat_r.r11 <= ONE_FIX && mat_r.r22 <= ONE_FIX))
    else $error("qfr_matrix: diagonal entry above one");

  a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && !out_ready |=> vb_r && $stable(mat_r) && $stable(acc_b_r))
    else $error("qfr_matrix: stalled entry lost");

  a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && !adv_a |=> va_r && $stable(pxy_r) && $stable(acc_a_r))
    else $error("qfr_matrix: first stage overwritten while stalled");

endmodule

FILE: design/qfr_apply.sv
// Two pipeline stages that multiply the acceleration vector by the rotation matrix.
// Stage one forms the nine products, stage two sums, rounds and saturates. Uses qfr_pkg.
module qfr_apply (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qfr_pkg::mat_t  in_mat,
  input  qfr_pkg::vec_t  in_accel,
  output logic           out_valid,
  input  logic           out_ready,
  output qfr_pkg::s16_t  out_world_x,
  output qfr_pkg::s16_t  out_world_y,
  output qfr_pkg::s16_t  out_world_z,
  output logic           out_clipped
);
  import qfr_pkg::*;

  function automatic prod_t mul(input s16_t a, input ent_t m);
    prod_t ae;
    prod_t me;
    ae = {{(PROD_W-IN_W){a[IN_W-1]}}, a};
    me = {{(PROD_W-ENT_W){m[ENT_W-1]}}, m};
    return ae * me;
  endfunction

  function automatic sum_t ext_sum(input prod_t p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  logic vc_r, vd_r;
  logic adv_c, adv_d;

  ent_t  ent [0:8];
  s16_t  acc [0:2];
  prod_t p_nxt [0:8];
  prod_t p_r   [0:8];
  sum_t  sum   [0:2];
  rnd_t  rnd   [0:2];
  s16_t  sat_nxt [0:2];
  logic [2:0] clip_nxt;
  s16_t  wx_r, wy_r, wz_r;
  logic  clip_r;

  assign adv_d    = out_ready || !vd_r;
  assign adv_c    = adv_d || !vc_r;
  assign in_ready = adv_c;

  assign ent[0] = in_mat.r00;
  assign ent[1] = in_mat.r01;
  assign ent[2] = in_mat.r02;
  assign ent[3] = in_mat.r10;
  assign ent[4] = in_mat.r11;
  assign ent[5] = in_mat.r12;
  assign ent[6] = in_mat.r20;
  assign ent[7] = in_mat.r21;
  assign ent[8] = in_mat.r22;
  assign acc[0] = in_accel.x;
  assign acc[1] = in_accel.y;
  assign acc[2] = in_accel.z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_nxt[r*3+c] = mul(acc[c], ent[r*3+c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (adv_c) vc_r <= in_valid;
      if (adv_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      for (int i = 0; i < 9; i++) begin
        p_r[i] <= p_nxt[i];
      end
    end
  end

  // floor((S + 2^27) / 2^28): round half up, then clamp
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = ext_sum(p_r[r*3]) + ext_sum(p_r[r*3+1]) + ext_sum(p_r[r*3+2]) + HALF_FIX;
      rnd[r] = sum[r][SUM_W-1:FRAC_BITS];
      if (rnd[r] > SAT_MAX) begin
        sat_nxt[r]  = s16_t'(SAT_MAX);
        clip_nxt[r] = 1'b1;
      end else if (rnd[r] < SAT_MIN) begin
        sat_nxt[r]  = s16_t'(SAT_MIN);
        clip_nxt[r] = 1'b1;
      end else begin
        sat_nxt[r]  = rnd[r][IN_W-1:0];
        clip_nxt[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_d) begin
      wx_r   <= sat_nxt[0];
      wy_r   <= sat_nxt[1];
      wz_r   <= sat_nxt[2];
      clip_r <= |clip_nxt;
    end
  end

  assign out_valid   = vd_r;
  assign out_world_x = wx_r;
  assign out_world_y = wy_r;
  assign out_world_z = wz_r;
  assign out_clipped = clip_r;

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r && clip_r |->
      (wx_r == 16'sh7fff || wx_r == -16'sh8000 || wy_r == 16'sh7fff ||
       wy_r == -16'sh8000 || wz_r == 16'sh7fff || wz_r == -16'sh8000))
    else $error("qfr_apply: clip flag without a clamped component");

  a_hold_d: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r && !out_ready |=> vd_r && $stable(wx_r) && $stable(clip_r))
    else $error("qfr_apply: stalled result changed");

  a_hold_c: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && !adv_c |=> vc_r && $stable(p_r[0]) && $stable(p_r[8]))
    else $error("qfr_apply: product stage overwritten while stalled");

endmodule

FILE: design/quaternion_frame_rotate.sv
// Quaternion frame rotation: body-frame acceleration to earth frame.
// Input channel: one request per cycle while in_ready is high, carrying the
//   quaternion parts (Q2.14, 16384 = 1.0, unnormalized) and body-frame accel.
// Result channel: one result per request, the rotated acceleration rounded
//   half up and saturated to signed 16 bits, with clipped set when any
//   component was clamped.
// Four register stages: quaternion products, matrix entries, vector
//   products, sum/round/saturate; a result becomes valid once its request
//   has passed all four. Throughput is one request per cycle while the
//   receiver is ready, set by the fully pipelined multiplier stages.
// Each stage advances when the next one is empty or moving, so a stalled
//   receiver fills the pipeline and in_ready falls only when all four
//   stages hold a request; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other
//   state and no configuration.
// Depends on qfr_pkg, qfr_matrix and qfr_apply.
module quaternion_frame_rotate (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qfr_pkg::s16_t  in_quat_w,
  input  qfr_pkg::s16_t  in_quat_x,
  input  qfr_pkg::s16_t  in_quat_y,
  input  qfr_pkg::s16_t  in_quat_z,
  input  qfr_pkg::s16_t  in_accel_x,
  input  qfr_pkg::s16_t  in_accel_y,
  input  qfr_pkg::s16_t  in_accel_z,
  output logic           out_valid,
  input  logic           out_ready,
  output qfr_pkg::s16_t  out_world_x,
  output qfr_pkg::s16_t  out_world_y,
  output qfr_pkg::s16_t  out_world_z,
  output logic           out_clipped
);
  import qfr_pkg::*;

  vec_t accel_in;
  vec_t accel_mid;
  mat_t mat_mid;
  logic mid_valid, mid_ready;

  assign accel_in.x = in_accel_x;
  assign accel_in.y = in_accel_y;
  assign accel_in.z = in_accel_z;

  qfr_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_quat_w (in_quat_w),
    .in_quat_x (in_quat_x),
    .in_quat_y (in_quat_y),
    .in_quat_z (in_quat_z),
    .in_accel  (accel_in),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_mat   (mat_mid),
    .out_accel (accel_mid)
  );

  qfr_apply u_apply (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (mid_valid),
    .in_ready    (mid_ready),
    .in_mat      (mat_mid),
    .in_accel    (accel_mid),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_world_x (out_world_x),
    .out_world_y (out_world_y),
    .out_world_z (out_world_z),
    .out_clipped (out_clipped)
  );

endmodule
